FILE: rtl/hpmc_pkg.sv
// ----------------------------------------------------------------------------
// Heater profile mode controller package
// Shared payload types, command and mode codes, and controller handshake types.
// ----------------------------------------------------------------------------
package hpmc_pkg;

   // Command codes of the request item.
   localparam logic [2:0] CMD_UPDATE      = 3'd0;
   localparam logic [2:0] CMD_SET_OFF     = 3'd1;
   localparam logic [2:0] CMD_START_RAMP  = 3'd2;
   localparam logic [2:0] CMD_START_HOLD  = 3'd3;
   localparam logic [2:0] CMD_START_TIMER = 3'd4;

   // Mode codes.
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_RAMP  = 2'd1;
   localparam logic [1:0] MODE_HOLD  = 2'd2;
   localparam logic [1:0] MODE_TIMER = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RAMP_START_TEMP = 2'd0;
   localparam logic [1:0] CSR_TARGET_TEMP     = 2'd1;
   localparam logic [1:0] CSR_DURATION_S      = 2'd2;
   localparam logic [1:0] CSR_TIMER_USE_TEMP  = 2'd3;

   localparam int MS_PER_S        = 1000;
   localparam int HYST_SIXTEENTHS = 16;

   // Duration in ms is below 65536 * 1000, which needs 26 bits.
   localparam int DUR_W = 26;
   // Ramp quotient magnitude is below 65536.
   localparam int QUO_W = 16;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

   typedef struct packed {
      logic [2:0]         cmd;
      logic [31:0]        now_ms;
      logic signed [15:0] sample_temp;
      logic               heater_fault;
   } req_type;

   typedef struct packed {
      logic               heater_on;
      logic signed [15:0] heater_target;
      logic [1:0]         mode_now;
      logic               completed;
      logic               faulted;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic eval;
      logic mul;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_stat_type;

endpackage

FILE: rtl/hpmc_ctrl.sv
// ----------------------------------------------------------------------------
// Heater profile mode controller sequencer
// Evaluate, multiply and serial divide (interpolating ramp only), then commit.
// ----------------------------------------------------------------------------
module hpmc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  hpmc_pkg::dp_stat_type stat,
   output hpmc_pkg::dp_cmd_type  dp_cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EVAL   = 5'b00010,
      S_MUL    = 5'b00100,
      S_DIV    = 5'b01000,
      S_COMMIT = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [hpmc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept;
   logic                         commit_ok;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // The result register must be free, or emptied this cycle, to take a new item.
   assign commit_ok = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = stat.need_div ? S_MUL : S_COMMIT;
         end
         S_MUL: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == hpmc_pkg::DIV_LAST) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (commit_ok) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = commit_ok || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      dp_cmd.latch    = accept;
      dp_cmd.eval     = (state_ff == S_EVAL);
      dp_cmd.mul      = (state_ff == S_MUL);
      dp_cmd.div_step = (state_ff == S_DIV);
      dp_cmd.commit   = commit_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/hpmc_dp.sv
// ----------------------------------------------------------------------------
// Heater profile mode controller datapath
// Configuration and mode state, ramp multiplier, restoring divider, result register.
// ----------------------------------------------------------------------------
module hpmc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   input  hpmc_pkg::req_type     req_data,
   input  hpmc_pkg::dp_cmd_type  dp_cmd,
   output hpmc_pkg::dp_stat_type stat,
   output hpmc_pkg::rsp_type     rsp_data
);

   localparam int DW = hpmc_pkg::DUR_W;
   localparam int QW = hpmc_pkg::QUO_W;

   // Configuration registers.
   logic signed [15:0] ramp_start_ff, ramp_start_in;
   logic signed [15:0] target_temp_ff, target_temp_in;
   logic [15:0]        duration_ff, duration_in;
   logic               timer_use_ff, timer_use_in;

   // Mode state.
   logic [1:0]         mode_ff, mode_in;
   logic [31:0]        start_time_ff, start_time_in;
   logic               running_ff, running_in;
   logic signed [15:0] target_ff, target_in;

   // Item and arithmetic registers.
   hpmc_pkg::req_type  item_ff, item_in;
   logic [DW-1:0]      elapsed_ff, elapsed_in;
   logic [QW-1:0]      mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [DW-1:0]      rem_ff, rem_in;
   logic [QW-1:0]      quo_ff, quo_in;
   hpmc_pkg::rsp_type  rsp_ff, rsp_in;

   logic [DW-1:0]      dur_ms;
   logic [31:0]        elapsed;
   logic               expired;
   logic signed [16:0] diff;
   logic [16:0]        diff_abs;
   logic [DW+QW-1:0]   product;
   logic [DW:0]        trial;
   logic               trial_fits;
   logic [16:0]        quo_signed;
   logic signed [15:0] ramp_target;
   logic signed [16:0] hyst_low;
   logic               below_band;
   logic               above_target;

   logic [1:0]         mode_n;
   logic [31:0]        start_time_n;
   logic               running_n;
   logic signed [15:0] target_n;
   logic               completed_n;
   logic               faulted_n;

   // ---------------- Configuration writes ----------------
   always_comb begin
      ramp_start_in  = ramp_start_ff;
      target_temp_in = target_temp_ff;
      duration_in    = duration_ff;
      timer_use_in   = timer_use_ff;
      if (csr_wen) begin
         unique case (csr_index)
            hpmc_pkg::CSR_RAMP_START_TEMP: ramp_start_in  = csr_wdata;
            hpmc_pkg::CSR_TARGET_TEMP:     target_temp_in = csr_wdata;
            hpmc_pkg::CSR_DURATION_S:      duration_in    = csr_wdata;
            hpmc_pkg::CSR_TIMER_USE_TEMP:  timer_use_in   = csr_wdata[0];
            default:                       ;
         endcase
      end
   end

   // ---------------- Shared arithmetic ----------------
   assign dur_ms  = {{(DW-16){1'b0}}, duration_ff} * DW'(hpmc_pkg::MS_PER_S);
   assign elapsed = item_ff.now_ms - start_time_ff;
   assign expired = elapsed >= {{(32-DW){1'b0}}, dur_ms};

   assign diff     = {target_temp_ff[15], target_temp_ff} - {ramp_start_ff[15], ramp_start_ff};
   assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);

   assign stat.need_div = (item_ff.cmd == hpmc_pkg::CMD_UPDATE) && !item_ff.heater_fault &&
                          (mode_ff == hpmc_pkg::MODE_RAMP) && !expired;

   // Product of magnitude and elapsed time; its quotient by dur_ms stays below 2^16,
   // so the upper part already lies below the divisor.
   assign product = (DW+QW)'(mag_ff) * (DW+QW)'(elapsed_ff);

   // One restoring division step per cycle.
   assign trial      = {rem_ff, quo_ff[QW-1]};
   assign trial_fits = trial >= {1'b0, dur_ms};

   always_comb begin
      item_in    = dp_cmd.latch ? req_data : item_ff;
      elapsed_in = dp_cmd.eval ? elapsed[DW-1:0] : elapsed_ff;
      mag_in     = dp_cmd.eval ? diff_abs[QW-1:0] : mag_ff;
      neg_in     = dp_cmd.eval ? diff[16] : neg_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (dp_cmd.mul) begin
         rem_in = product[DW+QW-1:QW];
         quo_in = product[QW-1:0];
      end else if (dp_cmd.div_step) begin
         rem_in = trial_fits ? DW'(trial - {1'b0, dur_ms}) : trial[DW-1:0];
         quo_in = {quo_ff[QW-2:0], trial_fits};
      end
   end

   // Quotient truncates toward zero: negate the magnitude for a falling ramp.
   assign quo_signed  = neg_ff ? 17'(-{1'b0, quo_ff}) : {1'b0, quo_ff};
   assign ramp_target = ramp_start_ff + quo_signed[15:0];

   assign hyst_low     = {target_ff[15], target_ff} - 17'(hpmc_pkg::HYST_SIXTEENTHS);
   assign below_band   = $signed({item_ff.sample_temp[15], item_ff.sample_temp}) < hyst_low;
   assign above_target = item_ff.sample_temp >= target_ff;

   // ---------------- Commit of one item ----------------
   always_comb begin
      mode_n       = mode_ff;
      start_time_n = start_time_ff;
      running_n    = running_ff;
      target_n     = target_ff;
      completed_n  = 1'b0;
      faulted_n    = 1'b0;
      unique case (item_ff.cmd)
         hpmc_pkg::CMD_UPDATE: begin
            if (item_ff.heater_fault) begin
               faulted_n = 1'b1;
               mode_n    = hpmc_pkg::MODE_OFF;
               running_n = 1'b0;
            end else begin
               unique case (mode_ff)
                  hpmc_pkg::MODE_OFF: running_n = 1'b0;
                  hpmc_pkg::MODE_RAMP: begin
                     if (expired) begin
                        target_n    = target_temp_ff;
                        completed_n = 1'b1;
                        mode_n      = hpmc_pkg::MODE_OFF;
                        running_n   = 1'b0;
                     end else begin
                        target_n  = ramp_target;
                        running_n = 1'b1;
                     end
                  end
                  hpmc_pkg::MODE_HOLD: begin
                     if (!running_ff && below_band) running_n = 1'b1;
                     else if (running_ff && above_target) running_n = 1'b0;
                  end
                  hpmc_pkg::MODE_TIMER: begin
                     running_n = 1'b1;
                     if (expired) begin
                        completed_n = 1'b1;
                        mode_n      = hpmc_pkg::MODE_OFF;
                        running_n   = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         hpmc_pkg::CMD_SET_OFF: begin
            mode_n    = hpmc_pkg::MODE_OFF;
            running_n = 1'b0;
         end
         hpmc_pkg::CMD_START_RAMP: begin
            mode_n       = hpmc_pkg::MODE_RAMP;
            start_time_n = item_ff.now_ms;
            target_n     = target_temp_ff;
            running_n    = 1'b1;
         end
         hpmc_pkg::CMD_START_HOLD: begin
            mode_n    = hpmc_pkg::MODE_HOLD;
            target_n  = target_temp_ff;
            running_n = 1'b1;
         end
         hpmc_pkg::CMD_START_TIMER: begin
            mode_n       = hpmc_pkg::MODE_TIMER;
            start_time_n = item_ff.now_ms;
            if (timer_use_ff) target_n = target_temp_ff;
            running_n    = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      mode_in       = dp_cmd.commit ? mode_n : mode_ff;
      start_time_in = dp_cmd.commit ? start_time_n : start_time_ff;
      running_in    = dp_cmd.commit ? running_n : running_ff;
      target_in     = dp_cmd.commit ? target_n : target_ff;
      rsp_in        = rsp_ff;
      if (dp_cmd.commit) begin
         rsp_in.heater_on     = running_n;
         rsp_in.heater_target = target_n;
         rsp_in.mode_now      = mode_n;
         rsp_in.completed     = completed_n;
         rsp_in.faulted       = faulted_n;
      end
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_start_ff  <= '0;
         target_temp_ff <= '0;
         duration_ff    <= '0;
         timer_use_ff   <= 1'b0;
         mode_ff        <= hpmc_pkg::MODE_OFF;
         start_time_ff  <= '0;
         running_ff     <= 1'b0;
         target_ff      <= '0;
      end else begin
         ramp_start_ff  <= ramp_start_in;
         target_temp_ff <= target_temp_in;
         duration_ff    <= duration_in;
         timer_use_ff   <= timer_use_in;
         mode_ff        <= mode_in;
         start_time_ff  <= start_time_in;
         running_ff     <= running_in;
         target_ff      <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      elapsed_ff <= elapsed_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      rsp_ff     <= rsp_in;
   end

endmodule

FILE: rtl/heater_profile_mode_controller_unit.sv
// ----------------------------------------------------------------------------
// Heater profile mode controller
// Off, ramp, hold and timer mode control of a heater, one result per item.
//
//   Channel  Ports                          Direction  Handshake
//   req      req_valid/req_ready/req_data   in         valid-ready
//   rsp      rsp_valid/rsp_ready/rsp_data   out        valid-ready
//   csr      csr_wen/csr_index/csr_wdata    in         write enable, no wait
//
// An item passes from acceptance through evaluate to commit; a ramp update that
// interpolates also passes through a multiply and the 16 step restoring divider.
// A new item is accepted once the previous one has been committed.
// A result waits in the output register; the next item computes meanwhile
// and is committed once that register is free. Reset is synchronous.
// ----------------------------------------------------------------------------
module heater_profile_mode_controller_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hpmc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hpmc_pkg::rsp_type rsp_data,
   input  logic              csr_wen,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   hpmc_pkg::dp_cmd_type  dp_cmd;
   hpmc_pkg::dp_stat_type dp_stat;

   hpmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   hpmc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .stat      (dp_stat),
      .rsp_data  (rsp_data)
   );

endmodule
